/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros used by offset_pursuit_unicycle_control
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/opuc_pkg.sv */
// ----------------------------------------------------------------------------
// opuc_pkg
// constants, register map and tables of the offset pursuit steering control
// ----------------------------------------------------------------------------
package opuc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    // register indexes
    localparam logic [2:0] REG_PURSUER_ID  = 3'd0;
    localparam logic [2:0] REG_TARGET_ID   = 3'd1;
    localparam logic [2:0] REG_ANG_GAIN    = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED   = 3'd3;
    localparam logic [2:0] REG_MAX_TURN    = 3'd4;
    localparam logic [2:0] REG_SIDE_OFFSET = 3'd5;
    localparam logic [2:0] REG_SIDE_RIGHT  = 3'd6;
    localparam logic [2:0] REG_CAPTURE_RAD = 3'd7;

    localparam logic [22:0] MAX_TURN_RESET = 23'd149179;
    localparam logic [23:0] NEAR_OFFSET    = 24'd26;

    localparam logic signed [33:0] Q29_PI       = 34'sd1686629713;
    localparam logic signed [33:0] Q29_HALF_PI  = 34'sd843314857;
    localparam logic signed [33:0] Q29_INV_GAIN = 34'sd326016436;

    localparam logic [0:0] FUNC_SAMPLE = 1'b0;
    localparam logic [0:0] FUNC_TICK   = 1'b1;

    // cordic arctangent table, Q29
    function automatic logic [29:0] atan_q29(input logic [4:0] i);
        case (i)
            5'd0:    atan_q29 = 30'd421657428;
            5'd1:    atan_q29 = 30'd248918915;
            5'd2:    atan_q29 = 30'd131521918;
            5'd3:    atan_q29 = 30'd66762579;
            5'd4:    atan_q29 = 30'd33510843;
            5'd5:    atan_q29 = 30'd16771757;
            5'd6:    atan_q29 = 30'd8387925;
            5'd7:    atan_q29 = 30'd4194218;
            5'd8:    atan_q29 = 30'd2097141;
            5'd9:    atan_q29 = 30'd1048575;
            5'd10:   atan_q29 = 30'd524288;
            5'd11:   atan_q29 = 30'd262144;
            5'd12:   atan_q29 = 30'd131072;
            5'd13:   atan_q29 = 30'd65536;
            5'd14:   atan_q29 = 30'd32768;
            5'd15:   atan_q29 = 30'd16384;
            5'd16:   atan_q29 = 30'd8192;
            5'd17:   atan_q29 = 30'd4096;
            5'd18:   atan_q29 = 30'd2048;
            5'd19:   atan_q29 = 30'd1024;
            5'd20:   atan_q29 = 30'd512;
            5'd21:   atan_q29 = 30'd256;
            5'd22:   atan_q29 = 30'd128;
            5'd23:   atan_q29 = 30'd64;
            default: atan_q29 = 30'd0;
        endcase
    endfunction

endpackage

/* sv/offset_pursuit_unicycle_control.sv */
// ----------------------------------------------------------------------------
// offset_pursuit_unicycle_control
// steers a pursuer toward a goal beside a target from pose samples and ticks
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | i_valid / o_ready     | i_func i_body_id i_pose_x i_pose_y i_pose_heading
//  out     | o_valid / i_ready     | o_linear_speed o_turn_rate o_captured
//  cfg     | psel penable pwrite   | paddr pwdata prdata, pready tied high
//
// a pose sample does not hold the input; a tick that gives a drive pair holds the
// input through the cordic rotations, two squarings, a root, two cross
// products, a restoring divide, a gain multiply and an output step
// reset clears state and the capture latch; configuration returns to defaults
// a stalled result holds in the output register; a finished tick waits for it
module offset_pursuit_unicycle_control
    import opuc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_body_id,
    input  logic signed [23:0] i_pose_x,
    input  logic signed [23:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_linear_speed,
    output logic signed [23:0] o_turn_rate,
    output logic               o_captured,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_SQX, S_SQY, S_ROOT, S_CRX, S_CRY,
        S_DIV, S_MUL, S_DONE
    } t_state;

    localparam int CW = $clog2(CORDIC_STEPS_MAX + 1);

    // configuration
    logic [7:0]  r_pursuer_id, r_target_id;
    logic [23:0] r_ang_gain;
    logic [22:0] r_max_speed, r_max_turn, r_side_offset, r_capture_rad;
    logic        r_side_right;
    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pursuer_id  <= '0;
            r_target_id   <= '0;
            r_ang_gain    <= '0;
            r_max_speed   <= '0;
            r_max_turn    <= MAX_TURN_RESET;
            r_side_offset <= '0;
            r_side_right  <= 1'b0;
            r_capture_rad <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PURSUER_ID:  r_pursuer_id  <= pwdata[7:0];
                REG_TARGET_ID:   r_target_id   <= pwdata[7:0];
                REG_ANG_GAIN:    r_ang_gain    <= pwdata[23:0];
                REG_MAX_SPEED:   r_max_speed   <= pwdata[22:0];
                REG_MAX_TURN:    r_max_turn    <= pwdata[22:0];
                REG_SIDE_OFFSET: r_side_offset <= pwdata[22:0];
                REG_SIDE_RIGHT:  r_side_right  <= pwdata[0];
                REG_CAPTURE_RAD: r_capture_rad <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_cfg_idx)
            REG_PURSUER_ID:  prdata = {24'd0, r_pursuer_id};
            REG_TARGET_ID:   prdata = {24'd0, r_target_id};
            REG_ANG_GAIN:    prdata = {8'd0, r_ang_gain};
            REG_MAX_SPEED:   prdata = {9'd0, r_max_speed};
            REG_MAX_TURN:    prdata = {9'd0, r_max_turn};
            REG_SIDE_OFFSET: prdata = {9'd0, r_side_offset};
            REG_SIDE_RIGHT:  prdata = {31'd0, r_side_right};
            REG_CAPTURE_RAD: prdata = {9'd0, r_capture_rad};
            default:         prdata = '0;
        endcase
    end

    // pose state
    logic signed [23:0] r_own_x, r_own_y, r_prey_x, r_prey_y;
    logic signed [15:0] r_own_hd;
    logic               r_seen, r_latch;

    // sequencer state
    t_state             r_state;
    logic               r_busy;
    logic [6:0]         r_cnt;
    logic               r_out_valid;
    logic signed [23:0] r_out_v, r_out_w;
    logic               r_out_cap;

    // work registers
    logic signed [25:0] r_dx, r_dy;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_neg;
    logic [50:0]        r_acc;     // sum of squares, then root remainder
    logic [25:0]        r_mcand;   // serial multiplicand magnitude
    logic [25:0]        r_mplier;  // serial multiplier bits
    logic [25:0]        r_root;
    logic [51:0]        r_rad;     // radicand under the root
    logic signed [19:0] r_hx, r_hy;
    logic signed [47:0] r_cross;   // c in Q15
    logic [63:0]        r_num;     // |c| << 16, shifted out as quotient bits
    logic [25:0]        r_rem;
    logic               r_qneg;
    logic [63:0]        r_prod;    // gain times quotient accumulator
    logic [39:0]        r_qmag;
    logic               r_cap;

    // combinational helpers
    logic               w_in_acc, w_out_acc;
    logic signed [24:0] w_off, w_gx;
    logic signed [25:0] w_dx, w_dy;
    logic signed [33:0] w_z0, w_ys, w_xs;
    logic [29:0]        w_atan;
    logic [24:0]        w_ex;
    logic [26:0]        w_rsub;
    logic [51:0]        w_rtrial;
    logic signed [64:0] w_wfull;
    logic signed [24:0] w_wclamp;
    logic signed [24:0] w_lim;

    assign o_ready   = !r_busy;
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_out_valid && i_ready;
    assign o_valid   = r_out_valid;
    assign o_linear_speed = r_out_v;
    assign o_turn_rate    = r_out_w;
    assign o_captured     = r_out_cap;

    // goal and distances from the stored poses
    assign w_off = (r_own_y > r_prey_y) ? $signed({2'b0, r_side_offset})
                                       : $signed({1'b0, NEAR_OFFSET});
    assign w_gx  = r_side_right ? (25'(r_prey_x) - w_off) : (25'(r_prey_x) + w_off);
    assign w_dx  = 26'(r_own_x) - 26'(w_gx);
    assign w_dy  = 26'(r_own_y) - 26'(r_prey_y);
    assign w_ex  = (r_own_x >= r_prey_x) ? 25'(26'(r_own_x) - 26'(r_prey_x))
                                          : 25'(26'(r_prey_x) - 26'(r_own_x));
    assign w_z0  = 34'(r_own_hd) <<< 16;

    // one cordic rotation
    assign w_atan = atan_q29(r_cnt[4:0]);
    assign w_ys   = r_cy >>> r_cnt[CW-1:0];
    assign w_xs   = r_cx >>> r_cnt[CW-1:0];

    // restoring root trial = (root << 2) | 1, and the divide's trial subtraction
    assign w_rtrial = 52'({r_root, 2'b01});
    assign w_rsub   = {r_rem, r_num[63]} - {1'b0, r_mcand};

    // gain product and clamp
    assign w_wfull  = r_qneg ? $signed({1'b0, r_prod}) : -$signed({1'b0, r_prod});
    assign w_lim    = $signed({2'b0, r_max_turn});
    always_comb begin
        logic signed [64:0] fl;
        // floor of the negated product over 2^31
        fl = w_wfull >>> 31;
        if (fl > 65'(w_lim))
            w_wclamp = w_lim;
        else if (fl < -65'(w_lim))
            w_wclamp = -w_lim;
        else
            w_wclamp = 25'(fl);
    end

    // remainder of the restoring root held in r_acc, radicand in r_rad
    logic [51:0] w_rem2;
    logic        w_rfit;
    assign w_rem2 = {r_acc[49:0], r_rad[51:50]};
    assign w_rfit = w_rem2 >= w_rtrial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
            r_latch     <= 1'b0;
            r_own_x     <= '0;
            r_own_y     <= '0;
            r_own_hd    <= '0;
            r_prey_x    <= '0;
            r_prey_y    <= '0;
            r_cnt       <= '0;
        end else begin
            if (w_out_acc)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_func == FUNC_SAMPLE) begin
                            if (i_body_id == r_pursuer_id) begin
                                r_own_x  <= i_pose_x;
                                r_own_y  <= i_pose_y;
                                r_own_hd <= i_pose_heading;
                                r_seen   <= 1'b1;
                            end else if (i_body_id == r_target_id) begin
                                r_prey_x <= i_pose_x;
                                r_prey_y <= i_pose_y;
                            end
                        end else if (r_seen && !r_latch) begin
                            r_busy  <= 1'b1;
                            r_state <= S_CORDIC;
                            r_cnt   <= '0;
                            r_dx    <= w_dx;
                            r_dy    <= w_dy;
                            r_cap   <= w_ex < {2'b0, r_capture_rad};
                            r_cx    <= Q29_INV_GAIN;
                            r_cy    <= '0;
                            // fold heading by pi into the half plane
                            if (w_z0 > Q29_HALF_PI) begin
                                r_cz  <= w_z0 - Q29_PI;
                                r_neg <= 1'b1;
                            end else if (w_z0 < -Q29_HALF_PI) begin
                                r_cz  <= w_z0 + Q29_PI;
                                r_neg <= 1'b1;
                            end else begin
                                r_cz  <= w_z0;
                                r_neg <= 1'b0;
                            end
                        end
                    end
                end
                S_CORDIC: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - $signed({4'b0, w_atan});
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + $signed({4'b0, w_atan});
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(CORDIC_STEPS - 1)) begin
                        r_state  <= S_SQX;
                        r_cnt    <= '0;
                        r_acc    <= '0;
                        r_mcand  <= r_dx[25] ? 26'(-r_dx) : 26'(r_dx);
                        r_mplier <= r_dx[25] ? 26'(-r_dx) : 26'(r_dx);
                    end
                end
                S_SQX, S_SQY: begin
                    // shift-add square, one multiplier bit a cycle
                    if (r_mplier[0])
                        r_acc <= r_acc + (51'(r_mcand) << r_cnt[4:0]);
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 7'd1;
                    if (r_cnt == 7'd25) begin
                        r_cnt <= '0;
                        if (r_state == S_SQX) begin
                            r_state  <= S_SQY;
                            r_mcand  <= r_dy[25] ? 26'(-r_dy) : 26'(r_dy);
                            r_mplier <= r_dy[25] ? 26'(-r_dy) : 26'(r_dy);
                        end else begin
                            r_state <= S_ROOT;
                            r_rad   <= {1'b0, (r_mplier[0] ?
                                       r_acc + (51'(r_mcand) << 25) : r_acc)};
                            r_acc   <= '0;
                            r_root  <= '0;
                            // finish cordic: unfold and floor to Q15
                            r_hx <= 20'((r_neg ? -r_cx : r_cx) >>> 14);
                            r_hy <= 20'((r_neg ? -r_cy : r_cy) >>> 14);
                        end
                    end
                end
                S_ROOT: begin
                    // two radicand bits a cycle, one root bit
                    if (w_rfit) begin
                        r_acc  <= 51'(w_rem2 - w_rtrial);
                        r_root <= {r_root[24:0], 1'b1};
                    end else begin
                        r_acc  <= 51'(w_rem2);
                        r_root <= {r_root[24:0], 1'b0};
                    end
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd25) begin
                        r_state  <= S_CRX;
                        r_cnt    <= '0;
                        r_cross  <= '0;
                        r_mplier <= r_dy[25] ? 26'(-r_dy) : 26'(r_dy);
                        r_qneg   <= r_dy[25];
                    end
                end
                S_CRX, S_CRY: begin
                    // hx*dy then minus hy*dx, one bit of |d| a cycle
                    if (r_mplier[0]) begin
                        if ((r_state == S_CRX) ^ r_qneg)
                            r_cross <= r_cross + ((48'(r_state == S_CRX ? r_hx : r_hy))
                                                  <<< r_cnt[4:0]);
                        else
                            r_cross <= r_cross - ((48'(r_state == S_CRX ? r_hx : r_hy))
                                                  <<< r_cnt[4:0]);
                    end
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 7'd1;
                    if (r_cnt == 7'd25) begin
                        r_cnt <= '0;
                        if (r_state == S_CRX) begin
                            r_state  <= S_CRY;
                            r_mplier <= r_dx[25] ? 26'(-r_dx) : 26'(r_dx);
                            r_qneg   <= r_dx[25];
                        end else begin
                            r_state <= S_DIV;
                            r_rem   <= '0;
                            r_mcand <= r_root;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd0) begin
                        // load |c| << 16 on entry to the divide
                        r_num  <= {r_cross[47] ? 48'(-r_cross) : 48'(r_cross), 16'd0};
                        r_qneg <= r_cross[47];
                        r_rem  <= '0;
                        r_cnt  <= 7'd1;
                    end else begin
                        // restoring divide, one quotient bit a cycle
                        if (!w_rsub[26]) begin
                            r_rem <= w_rsub[25:0];
                            r_num <= {r_num[62:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[24:0], r_num[63]};
                            r_num <= {r_num[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd64) begin
                            r_state  <= S_MUL;
                            r_cnt    <= '0;
                            r_prod   <= '0;
                            r_qmag   <= 40'(w_rsub[26] ? {r_num[62:0], 1'b0}
                                                       : {r_num[62:0], 1'b1});
                            r_mplier <= 26'(r_ang_gain);
                        end
                    end
                end
                S_MUL: begin
                    // gain times |q|, one gain bit a cycle
                    if (r_mplier[0])
                        r_prod <= r_prod + (64'(r_qmag) << r_cnt[4:0]);
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 7'd1;
                    if (r_cnt == 7'd23)
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || w_out_acc) begin
                        r_out_valid <= 1'b1;
                        r_busy      <= 1'b0;
                        r_state     <= S_IDLE;
                        if (r_cap) begin
                            r_out_v   <= '0;
                            r_out_w   <= '0;
                            r_out_cap <= 1'b1;
                            r_latch   <= 1'b1;
                        end else begin
                            r_out_v   <= $signed({1'b0, r_max_speed});
                            r_out_w   <= (r_root == '0) ? '0 : 24'(w_wclamp);
                            r_out_cap <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, r_busy, !o_ready)
    `ASSERT_NEXT(a_cap_latches, i_clk, i_rst_n, w_out_acc && o_captured, r_latch)
    `ASSERT_IMPL(a_cap_zero, i_clk, i_rst_n, o_valid && o_captured,
                 o_turn_rate == 24'sd0 && o_linear_speed == 24'sd0)

endmodule
